@@ design/pif_pkg.sv @@
// shared constants and types of the pairwise interaction force core
`default_nettype none
package pif_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int COORD_W       = 32;
   localparam int LEN_W         = 31;
   localparam int UNIT_W        = 18;
   localparam int FORCE_W       = 32;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;
   localparam int SQRT_STEPS    = 32;
   localparam int DIV_STEPS     = 31;

   typedef enum logic [1:0] {
      ZONE_OUT    = 2'd0,
      ZONE_REPEL  = 2'd1,
      ZONE_RELATE = 2'd2
   } zone_type;

   typedef enum logic {
      REG_PEAK_ATTRACT = 1'b0,
      REG_PEAK_REPEL   = 1'b1
   } reg_index_type;
endpackage
`default_nettype wire

@@ design/pif_req_if.sv @@
// request channel carrying one particle pair
`default_nettype none
interface pif_req_if import pif_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [COORD_W-1:0] conn_x;
   logic signed [COORD_W-1:0] conn_y;
   logic [LEN_W-1:0]          own_radius;
   logic [LEN_W-1:0]          target_radius;
   logic [LEN_W-1:0]          max_reach;
   logic signed [UNIT_W-1:0]  affinity;
   logic signed [UNIT_W-1:0]  fallback_dir_x;
   logic signed [UNIT_W-1:0]  fallback_dir_y;

   modport source (
      output valid, conn_x, conn_y, own_radius, target_radius, max_reach,
             affinity, fallback_dir_x, fallback_dir_y,
      input  ready
   );
   modport sink (
      input  valid, conn_x, conn_y, own_radius, target_radius, max_reach,
             affinity, fallback_dir_x, fallback_dir_y,
      output ready
   );
endinterface
`default_nettype wire

@@ design/pif_rsp_if.sv @@
// result channel carrying one pair force
`default_nettype none
interface pif_rsp_if import pif_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FORCE_W-1:0] force_x;
   logic signed [FORCE_W-1:0] force_y;
   zone_type                  zone;

   modport source (output valid, force_x, force_y, zone, input ready);
   modport sink (input valid, force_x, force_y, zone, output ready);
endinterface
`default_nettype wire

@@ design/pairwise_interaction_force_core.sv @@
// pair force pipeline: distance, unit direction, profile, saturated force
// throughput: one request per cycle while no result waits unaccepted; the 32-stage square root and the
//   31-stage dividers each retire one bit per stage
// the whole pipeline freezes while a result waits unaccepted
// reset (synchronous) clears all valid bits and sets both strengths to 1.0
`default_nettype none
module pairwise_interaction_force_core import pif_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   pif_req_if.sink               req_ch,
   pif_rsp_if.source             rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);
   localparam int LAT   = 4 + SQRT_STEPS + DIV_STEPS + 3;
   localparam int LANES = 3;
   localparam int LANE_STR = 0;
   localparam int LANE_X   = 1;
   localparam int LANE_Y   = 2;
   localparam int DIV_W = COORD_W;
   localparam int UW  = (FRAC_BITS + 1 > UNIT_W) ? FRAC_BITS + 1 : UNIT_W;
   localparam int PSW = LEN_W + UNIT_W;
   localparam int SW  = (PSW - FRAC_BITS > LEN_W) ? PSW - FRAC_BITS : LEN_W;
   localparam int FW  = SW + UW;
   localparam int NDW = COORD_W + FRAC_BITS;

   typedef struct packed {
      logic                     sx;
      logic                     sy;
      logic [COORD_W-1:0]       ax;
      logic [COORD_W-1:0]       ay;
      logic [LEN_W-1:0]         own;
      logic [LEN_W-1:0]         tgt;
      logic [LEN_W-1:0]         reach;
      logic signed [UNIT_W-1:0] aff;
      logic signed [UNIT_W-1:0] fbx;
      logic signed [UNIT_W-1:0] fby;
   } pair_type;

   typedef struct packed {
      zone_type                 zone;
      logic                     d_zero;
      logic                     sx;
      logic                     sy;
      logic signed [UNIT_W-1:0] aff;
      logic signed [UNIT_W-1:0] fbx;
      logic signed [UNIT_W-1:0] fby;
   } mid_type;

   // configuration registers
   logic [LEN_W-1:0] peak_attract_ff;
   logic [LEN_W-1:0] peak_repel_ff;
   logic             csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_attract_ff <= LEN_W'(1) << FRAC_BITS;
         peak_repel_ff   <= LEN_W'(1) << FRAC_BITS;
      end else if (csr_wr) begin
         unique case (reg_index_type'(paddr[CSR_ADDR_W-1]))
            REG_PEAK_ATTRACT: peak_attract_ff <= pwdata[LEN_W-1:0];
            REG_PEAK_REPEL:   peak_repel_ff   <= pwdata[LEN_W-1:0];
            default:          peak_repel_ff   <= peak_repel_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(paddr[CSR_ADDR_W-1]))
         REG_PEAK_ATTRACT: prdata = CSR_DATA_W'(peak_attract_ff);
         REG_PEAK_REPEL:   prdata = CSR_DATA_W'(peak_repel_ff);
         default:          prdata = '0;
      endcase
   end

   // pipeline control
   logic           adv;
   logic [LAT-1:0] vld_ff;

   assign adv          = !vld_ff[LAT-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_ch.valid};
      end
   end

   // stage a: magnitudes and squares
   logic [COORD_W-1:0] ax_in, ay_in;
   logic [63:0]        sqx_in, sqy_in;
   pair_type           a_pay_ff;
   logic [63:0]        a_sqx_ff, a_sqy_ff;

   always_comb begin
      ax_in  = req_ch.conn_x[COORD_W-1] ? COORD_W'(-req_ch.conn_x) : COORD_W'(req_ch.conn_x);
      ay_in  = req_ch.conn_y[COORD_W-1] ? COORD_W'(-req_ch.conn_y) : COORD_W'(req_ch.conn_y);
      sqx_in = 64'(ax_in) * 64'(ax_in);
      sqy_in = 64'(ay_in) * 64'(ay_in);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_pay_ff.sx    <= req_ch.conn_x[COORD_W-1];
         a_pay_ff.sy    <= req_ch.conn_y[COORD_W-1];
         a_pay_ff.ax    <= ax_in;
         a_pay_ff.ay    <= ay_in;
         a_pay_ff.own   <= req_ch.own_radius;
         a_pay_ff.tgt   <= req_ch.target_radius;
         a_pay_ff.reach <= req_ch.max_reach;
         a_pay_ff.aff   <= req_ch.affinity;
         a_pay_ff.fbx   <= req_ch.fallback_dir_x;
         a_pay_ff.fby   <= req_ch.fallback_dir_y;
         a_sqx_ff       <= sqx_in;
         a_sqy_ff       <= sqy_in;
      end
   end

   // stage b and square root, one root bit per stage
   pair_type    sq_pay_ff [SQRT_STEPS+1];
   logic [63:0] sq_n_ff   [SQRT_STEPS+1];
   logic [63:0] sq_r_ff   [SQRT_STEPS+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_pay_ff[0] <= a_pay_ff;
         sq_n_ff[0]   <= a_sqx_ff + a_sqy_ff;
         sq_r_ff[0]   <= '0;
      end
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'(1) << (2 * (SQRT_STEPS - 1 - k));
      logic [63:0] trial;
      assign trial = sq_r_ff[k] + BIT;
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_pay_ff[k+1] <= sq_pay_ff[k];
            if (sq_n_ff[k] >= trial) begin
               sq_n_ff[k+1] <= sq_n_ff[k] - trial;
               sq_r_ff[k+1] <= (sq_r_ff[k] >> 1) + BIT;
            end else begin
               sq_n_ff[k+1] <= sq_n_ff[k];
               sq_r_ff[k+1] <= sq_r_ff[k] >> 1;
            end
         end
      end
   end

   // stage p: zone decision and profile numerator
   pair_type             pp;
   logic [COORD_W-1:0]   d;
   logic [COORD_W-1:0]   reach_own, overlap_lim;
   logic [COORD_W:0]     d2, tdist;
   logic                 degen;
   logic [LEN_W-1:0]     wid;
   logic [LEN_W-1:0]     num_in;
   mid_type              p_mid_in;
   mid_type              p_mid_ff;
   logic [DIV_W-1:0]     p_d_ff, p_w_ff;
   logic [LEN_W-1:0]     p_num_ff;
   logic [COORD_W-1:0]   p_ax_ff, p_ay_ff;

   always_comb begin
      pp          = sq_pay_ff[SQRT_STEPS];
      d           = sq_r_ff[SQRT_STEPS][COORD_W-1:0];
      reach_own   = COORD_W'(pp.reach) + COORD_W'(pp.own);
      overlap_lim = COORD_W'(pp.own) + COORD_W'(pp.tgt);
      degen       = pp.reach <= pp.own;
      wid         = pp.reach - pp.own;
      d2          = {d, 1'b0};
      tdist       = (d2 >= (COORD_W+1)'(reach_own)) ? d2 - (COORD_W+1)'(reach_own)
                                                    : (COORD_W+1)'(reach_own) - d2;
      num_in      = (!degen && tdist < (COORD_W+1)'(wid)) ? LEN_W'((COORD_W+1)'(wid) - tdist)
                                                          : '0;
      p_mid_in.d_zero = d == '0;
      p_mid_in.sx     = pp.sx;
      p_mid_in.sy     = pp.sy;
      p_mid_in.aff    = pp.aff;
      p_mid_in.fbx    = pp.fbx;
      p_mid_in.fby    = pp.fby;
      priority if (d >= reach_own) begin
         p_mid_in.zone = ZONE_OUT;
      end else if (d < overlap_lim) begin
         p_mid_in.zone = ZONE_REPEL;
      end else begin
         p_mid_in.zone = ZONE_RELATE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_mid_ff <= p_mid_in;
         p_d_ff   <= (d == '0) ? DIV_W'(1) : d;
         p_w_ff   <= degen ? DIV_W'(1) : DIV_W'(wid);
         p_num_ff <= num_in;
         p_ax_ff  <= pp.ax;
         p_ay_ff  <= pp.ay;
      end
   end

   // stage m: numerators, then three restoring dividers in lockstep
   mid_type              md_ff     [DIV_STEPS+1];
   logic [DIV_W-1:0]     dv_rem_ff [LANES][DIV_STEPS+1];
   logic [DIV_STEPS-1:0] dv_lo_ff  [LANES][DIV_STEPS+1];
   logic [DIV_W-1:0]     dv_div_ff [LANES][DIV_STEPS+1];
   logic [2*LEN_W-1:0]   str_num_in;
   logic [NDW-1:0]       nx_in, ny_in;

   always_comb begin
      str_num_in = (2*LEN_W)'(peak_attract_ff) * (2*LEN_W)'(p_num_ff);
      nx_in      = {p_ax_ff, FRAC_BITS'(0)};
      ny_in      = {p_ay_ff, FRAC_BITS'(0)};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         md_ff[0]               <= p_mid_ff;
         dv_rem_ff[LANE_STR][0] <= DIV_W'(str_num_in >> DIV_STEPS);
         dv_lo_ff[LANE_STR][0]  <= str_num_in[DIV_STEPS-1:0];
         dv_div_ff[LANE_STR][0] <= p_w_ff;
         dv_rem_ff[LANE_X][0]   <= DIV_W'(nx_in >> DIV_STEPS);
         dv_lo_ff[LANE_X][0]    <= nx_in[DIV_STEPS-1:0];
         dv_div_ff[LANE_X][0]   <= p_d_ff;
         dv_rem_ff[LANE_Y][0]   <= DIV_W'(ny_in >> DIV_STEPS);
         dv_lo_ff[LANE_Y][0]    <= ny_in[DIV_STEPS-1:0];
         dv_div_ff[LANE_Y][0]   <= p_d_ff;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (adv) begin
            md_ff[k+1] <= md_ff[k];
         end
      end
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DIV_W:0] cat;
         logic           take;
         assign cat  = {dv_rem_ff[l][k], dv_lo_ff[l][k][DIV_STEPS-1]};
         assign take = cat >= {1'b0, dv_div_ff[l][k]};
         always_ff @(posedge clock) begin
            if (adv) begin
               dv_rem_ff[l][k+1] <= take ? DIV_W'(cat - {1'b0, dv_div_ff[l][k]})
                                         : cat[DIV_W-1:0];
               dv_lo_ff[l][k+1]  <= {dv_lo_ff[l][k][DIV_STEPS-2:0], take};
               dv_div_ff[l][k+1] <= dv_div_ff[l][k];
            end
         end
      end
   end

   // stage s: force magnitude and direction select
   mid_type           sm;
   logic [UNIT_W-1:0] aff_mag, fbx_mag, fby_mag;
   logic [PSW-1:0]    s_prod;
   logic [SW-1:0]     s_mag_in;
   logic [SW-1:0]     s_mag_ff;
   logic              s_neg_ff;
   logic [UW-1:0]     ux_ff, uy_ff;
   logic              ux_neg_ff, uy_neg_ff;

   always_comb begin
      sm       = md_ff[DIV_STEPS];
      aff_mag  = sm.aff[UNIT_W-1] ? UNIT_W'(-sm.aff) : UNIT_W'(sm.aff);
      fbx_mag  = sm.fbx[UNIT_W-1] ? UNIT_W'(-sm.fbx) : UNIT_W'(sm.fbx);
      fby_mag  = sm.fby[UNIT_W-1] ? UNIT_W'(-sm.fby) : UNIT_W'(sm.fby);
      s_prod   = PSW'(dv_lo_ff[LANE_STR][DIV_STEPS]) * PSW'(aff_mag);
      unique case (sm.zone)
         ZONE_REPEL:  s_mag_in = SW'(peak_repel_ff);
         ZONE_RELATE: s_mag_in = SW'(s_prod >> FRAC_BITS);
         default:     s_mag_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_mag_ff  <= s_mag_in;
         s_neg_ff  <= (sm.zone == ZONE_REPEL) || sm.aff[UNIT_W-1];
         ux_ff     <= sm.d_zero ? UW'(fbx_mag) : UW'(dv_lo_ff[LANE_X][DIV_STEPS]);
         uy_ff     <= sm.d_zero ? UW'(fby_mag) : UW'(dv_lo_ff[LANE_Y][DIV_STEPS]);
         ux_neg_ff <= sm.d_zero ? sm.fbx[UNIT_W-1] : sm.sx;
         uy_neg_ff <= sm.d_zero ? sm.fby[UNIT_W-1] : sm.sy;
      end
   end

   // stage f: component products
   logic [FW-1:0] fx_prod_ff, fy_prod_ff;
   logic          fx_neg_ff, fy_neg_ff;
   zone_type      zone_s_ff, zone_f_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         zone_s_ff  <= sm.zone;
         zone_f_ff  <= zone_s_ff;
         fx_prod_ff <= FW'(s_mag_ff) * FW'(ux_ff);
         fy_prod_ff <= FW'(s_mag_ff) * FW'(uy_ff);
         fx_neg_ff  <= s_neg_ff ^ ux_neg_ff;
         fy_neg_ff  <= s_neg_ff ^ uy_neg_ff;
      end
   end

   // output stage: shift and saturate
   logic [FW-1:0]      mx, my;
   logic [FORCE_W-1:0] fx_in, fy_in;
   logic [FORCE_W-1:0] force_x_ff, force_y_ff;
   zone_type           zone_ff;

   always_comb begin
      mx = fx_prod_ff >> FRAC_BITS;
      my = fy_prod_ff >> FRAC_BITS;
      if (fx_neg_ff) begin
         fx_in = (mx > FW'(64'h8000_0000)) ? FORCE_W'(32'h8000_0000) : FORCE_W'(FW'(0) - mx);
      end else begin
         fx_in = (mx > FW'(64'h7fff_ffff)) ? FORCE_W'(32'h7fff_ffff) : FORCE_W'(mx);
      end
      if (fy_neg_ff) begin
         fy_in = (my > FW'(64'h8000_0000)) ? FORCE_W'(32'h8000_0000) : FORCE_W'(FW'(0) - my);
      end else begin
         fy_in = (my > FW'(64'h7fff_ffff)) ? FORCE_W'(32'h7fff_ffff) : FORCE_W'(my);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         force_x_ff <= fx_in;
         force_y_ff <= fy_in;
         zone_ff    <= zone_f_ff;
      end
   end

   assign rsp_ch.valid   = vld_ff[LAT-1];
   assign rsp_ch.force_x = force_x_ff;
   assign rsp_ch.force_y = force_y_ff;
   assign rsp_ch.zone    = zone_ff;

`ifndef ASSERT_OFF
   a_reset_clears: assert property (@(posedge clock) $past(reset) |-> !rsp_ch.valid)
      else $error("result valid right after reset");

   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.zone == ZONE_OUT |-> rsp_ch.force_x == '0 && rsp_ch.force_y == '0)
      else $error("nonzero force out of reach");

   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAT-4] |-> dv_lo_ff[LANE_X][DIV_STEPS] <= (DIV_STEPS'(1) << FRAC_BITS)
                     && dv_lo_ff[LANE_Y][DIV_STEPS] <= (DIV_STEPS'(1) << FRAC_BITS))
      else $error("unit direction above one");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> $stable(vld_ff))
      else $error("pipeline moved during stall");
`endif
endmodule
`default_nettype wire

@@ dv/pif_force_checker.sv @@
// checker: watches both channels and the register port, predicts each pair force, compares
module pif_force_checker import pif_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pif_req_if                    req,
   pif_rsp_if                    rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    errors,
   output int                    pending
);
   typedef struct {
      logic signed [FORCE_W-1:0] fx;
      logic signed [FORCE_W-1:0] fy;
      zone_type                  zone;
   } pair_force_type;

   localparam int FB = FRAC_BITS_DEF;

   longint unsigned attract_peak;
   longint unsigned repel_peak;
   pair_force_type  force_q[$];

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint trunc_shift(longint v);
      longint unsigned m;
      if (v < 0) begin
         m = -v;
         return -longint'(m >> FB);
      end
      m = v;
      return longint'(m >> FB);
   endfunction

   function automatic longint unit_comp(longint c, longint unsigned d);
      longint unsigned mag;
      longint q;
      mag = (c < 0) ? -c : c;
      q = longint'((mag << FB) / d);
      return (c < 0) ? -q : q;
   endfunction

   function automatic logic signed [FORCE_W-1:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic pair_force_type pair_force(
      logic signed [COORD_W-1:0] cxv, logic signed [COORD_W-1:0] cyv,
      logic [LEN_W-1:0] ownv, logic [LEN_W-1:0] tgtv, logic [LEN_W-1:0] reachv,
      logic signed [UNIT_W-1:0] affv, logic signed [UNIT_W-1:0] fbxv,
      logic signed [UNIT_W-1:0] fbyv);
      pair_force_type res;
      longint cx, cy, ux, uy, s, aff;
      longint unsigned ax, ay, d, own, tgt, reach, w, m2, d2, t, str;
      cx = cxv; cy = cyv; aff = affv;
      own = ownv; tgt = tgtv; reach = reachv;
      ax = (cx < 0) ? -cx : cx;
      ay = (cy < 0) ? -cy : cy;
      d = int_sqrt(ax * ax + ay * ay);
      res.fx = 0; res.fy = 0; res.zone = ZONE_OUT;
      if (d >= reach + own) return res;
      if (d == 0) begin
         ux = fbxv; uy = fbyv;
      end else begin
         ux = unit_comp(cx, d); uy = unit_comp(cy, d);
      end
      if (d < own + tgt) begin
         s = -longint'(repel_peak);
         res.zone = ZONE_REPEL;
      end else begin
         str = 0;
         res.zone = ZONE_RELATE;
         if (reach > own) begin
            w = reach - own;
            m2 = reach + own;
            d2 = d << 1;
            t = (d2 >= m2) ? d2 - m2 : m2 - d2;
            if (t < w) str = attract_peak * (w - t) / w;
         end
         s = trunc_shift(longint'(str) * aff);
      end
      res.fx = clip32(trunc_shift(s * ux));
      res.fy = clip32(trunc_shift(s * uy));
      return res;
   endfunction

   always @(posedge clock) begin
      pair_force_type exp_f;
      if (reset) begin
         attract_peak = 65536;
         repel_peak = 65536;
         force_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[CSR_ADDR_W-1:2] == REG_PEAK_ATTRACT)
               attract_peak = 64'(pwdata[30:0]);
            else if (paddr[CSR_ADDR_W-1:2] == REG_PEAK_REPEL)
               repel_peak = 64'(pwdata[30:0]);
         end
         if (rsp.valid && rsp.ready) begin
            if (force_q.size() == 0) begin
               $error("force result with no request waiting");
               errors++;
            end else begin
               exp_f = force_q.pop_front();
               if (rsp.force_x !== exp_f.fx) begin
                  $error("force_x expected %0d actual %0d", exp_f.fx, rsp.force_x);
                  errors++;
               end
               if (rsp.force_y !== exp_f.fy) begin
                  $error("force_y expected %0d actual %0d", exp_f.fy, rsp.force_y);
                  errors++;
               end
               if (rsp.zone !== exp_f.zone) begin
                  $error("zone expected %0d actual %0d", exp_f.zone, rsp.zone);
                  errors++;
               end
            end
         end
         if (req.valid && req.ready)
            force_q.insert(force_q.size(), pair_force(req.conn_x, req.conn_y,
               req.own_radius, req.target_radius, req.max_reach, req.affinity,
               req.fallback_dir_x, req.fallback_dir_y));
      end
      pending = force_q.size();
   end

   initial begin
      errors = 0;
      pending = 0;
   end
endmodule

@@ dv/tb_top.sv @@
// testbench top: clock, reset, pair stimulus, register phases and verdict
module tb_top;
   import pif_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    errors, pending;
   int                    sent = 0;
   bit                    hold_off = 1'b0;

   pif_req_if req_ch();
   pif_rsp_if rsp_ch();

   pairwise_interaction_force_core DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   pif_force_checker checker_i (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
   );

   always #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.conn_x = '0; req_ch.conn_y = '0;
      req_ch.own_radius = '0; req_ch.target_radius = '0; req_ch.max_reach = '0;
      req_ch.affinity = '0; req_ch.fallback_dir_x = '0; req_ch.fallback_dir_y = '0;
   end

   // receiver: random stall pattern, plus one long hold-off on request
   initial begin
      int mode;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end
         mode = $urandom_range(0, 3);
         repeat (64) begin
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
            @(negedge clock);
         end
      end
   end

   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_W-1:0] val);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= CSR_ADDR_W'(idx) << 2; pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // drives one request and returns at the falling edge after acceptance
   task automatic send_pair(int cx, int cy, int own, int tgt, int reach,
      int aff, int fbx, int fby);
      req_ch.valid <= 1'b1;
      req_ch.conn_x <= cx; req_ch.conn_y <= cy;
      req_ch.own_radius <= 31'(own); req_ch.target_radius <= 31'(tgt);
      req_ch.max_reach <= 31'(reach);
      req_ch.affinity <= 18'(aff); req_ch.fallback_dir_x <= 18'(fbx);
      req_ch.fallback_dir_y <= 18'(fby);
      do @(posedge clock); while (!req_ch.ready);
      sent++;
      @(negedge clock);
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   function automatic int unit_val();
      return int'($urandom_range(0, 131072)) - 65536;
   endfunction

   task automatic send_random();
      int k;
      longint unsigned own, tgt, reach, span;
      longint cx, cy;
      int fbx, fby;
      fbx = unit_val(); fby = unit_val();
      if ($urandom_range(0, 9) < 2) begin
         send_pair($urandom, $urandom, $urandom, $urandom, $urandom,
                   unit_val(), fbx, fby);
      end else begin
         k = $urandom_range(2, 28);
         own = $urandom % (64'd1 << k);
         tgt = $urandom % (64'd1 << k);
         reach = $urandom % (64'd1 << (k + 1));
         span = (reach + own) * 3 / 4 + 1;
         cx = longint'($urandom % span) * (($urandom_range(0, 1) == 1) ? -1 : 1);
         cy = longint'($urandom % span) * (($urandom_range(0, 1) == 1) ? -1 : 1);
         if ($urandom_range(0, 19) == 0) begin
            cx = 0; cy = 0;
         end
         send_pair(int'(cx), int'(cy), int'(own), int'(tgt), int'(reach),
                   unit_val(), fbx, fby);
      end
   endtask

   task automatic directed_pairs();
      // zero distance takes the fallback direction, extremes of it
      send_pair(0, 0, 100, 100, 200, 65536, 65536, -65536);
      send_pair(0, 0, 0, 0, 200, -65536, -65536, 65536);
      send_pair(0, 0, 0, 0, 0, 65536, 65536, 65536);
      // extreme connector values
      send_pair(32'sh8000_0000, 32'sh8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff, -65536, 0, 0);
      send_pair(32'sh7fff_ffff, 32'sh8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff,
                65536, 0, 0);
      send_pair(32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0, 0, 65536, 0, 0);
      // overlap repulsion
      send_pair(3 << 16, 4 << 16, 4 << 16, 4 << 16, 20 << 16, 65536, 0, 0);
      send_pair(-(1 << 16), 0, 1 << 16, 1 << 16, 9 << 16, -65536, 0, 0);
      // relation profile, peak, edges and both affinity signs
      send_pair(6 << 16, 8 << 16, 0, 1 << 16, 20 << 16, 65536, 0, 0);
      send_pair(0, 15 << 16, 1 << 16, 1 << 16, 29 << 16, -65536, 0, 0);
      send_pair(-(2 << 16), 0, 1 << 16, 1 << 16, 9 << 16, 32768, 0, 0);
      send_pair(0, -(9 << 16), 1 << 16, 1 << 16, 9 << 16, -1, 0, 0);
      // degenerate reach
      send_pair(5 << 16, 0, 10 << 16, 1 << 16, 3 << 16, 65536, 0, 0);
      send_pair(5 << 16, 0, 10 << 16, 1 << 16, 10 << 16, 65536, 0, 0);
      // out of reach
      send_pair(30 << 16, 40 << 16, 1 << 16, 1 << 16, 10 << 16, 65536, 0, 0);
      send_pair(0, 11 << 16, 1 << 16, 1 << 16, 10 << 16, 65536, 0, 0);
   endtask

   task automatic random_phase(int n, bit with_hold);
      int left, burst;
      left = n;
      while (left > 0) begin
         burst = $urandom_range(1, 30);
         if (burst > left) burst = left;
         if (with_hold && left < n / 2 && !hold_off && with_hold) begin
            hold_off = 1'b1;
            with_hold = 1'b0;
         end
         repeat (burst) send_random();
         left -= burst;
         idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end
      idle_gap(1);
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      directed_pairs();
      idle_gap(1);
      random_phase(300, 0);
      drain();
      csr_write(REG_PEAK_ATTRACT, 32'h7fff_ffff);
      csr_write(REG_PEAK_REPEL, 32'h7fff_ffff);
      directed_pairs();
      random_phase(330, 1);
      drain();
      csr_write(REG_PEAK_ATTRACT, 0);
      csr_write(REG_PEAK_REPEL, 0);
      random_phase(300, 0);
      drain();
      csr_write(REG_PEAK_ATTRACT, $urandom);
      csr_write(REG_PEAK_REPEL, $urandom);
      random_phase(350, 0);
      drain();
      csr_write(REG_PEAK_ATTRACT, 1);
      csr_write(REG_PEAK_REPEL, $urandom_range(1, 1 << 20));
      directed_pairs();
      random_phase(320, 0);
      drain();
      if (errors == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end
endmodule
